// File: sv/ebec_pkg.sv
package ebec_pkg;

    // quadrature counter width
    localparam int DEF_COUNT_BITS = 16;
    localparam int ENC_PORT_BITS  = 16;

    localparam int TICK_BITS  = 8;
    localparam int CLICK_BITS = 2;
    localparam int CODE_BITS  = 4;
    localparam int ADDR_BITS  = 5;
    localparam int DATA_BITS  = 32;

    typedef logic [TICK_BITS-1:0] tick_t;
    typedef logic [CODE_BITS-1:0] code_t;

    // register indexes on the config port
    typedef enum logic [2:0] {
        REG_PRESS_DEBOUNCE = 3'd0,
        REG_RELEASE_GAP    = 3'd1,
        REG_LONG_PRESS     = 3'd2,
        REG_FAST_WINDOW    = 3'd3,
        REG_STEP_THRESHOLD = 3'd4
    } reg_index_t;

    localparam tick_t RST_PRESS_DEBOUNCE = 8'd2;
    localparam tick_t RST_RELEASE_GAP    = 8'd25;
    localparam tick_t RST_LONG_PRESS     = 8'd100;
    localparam tick_t RST_FAST_WINDOW    = 8'd7;
    localparam tick_t RST_STEP_THRESHOLD = 8'd2;

    localparam tick_t TICK_MAX = 8'd255;
    localparam logic [CLICK_BITS-1:0] CLICK_MAX = 2'd3;

    localparam code_t EV_NONE   = 4'd0;
    localparam code_t EV_SHORT  = 4'd1;
    localparam code_t EV_DOUBLE = 4'd2;
    localparam code_t EV_LONG   = 4'd3;
    localparam code_t EV_RIGHT  = 4'd4;
    localparam code_t EV_LEFT   = 4'd7;
    localparam code_t EV_LAST   = 4'd9;
    // offsets from the plain rotation code
    localparam code_t EV_FAST_OFS    = 4'd1;
    localparam code_t EV_PRESSED_OFS = 4'd2;

    function automatic tick_t sat_inc(input tick_t v);
        sat_inc = (v == TICK_MAX) ? TICK_MAX : v + tick_t'(1);
    endfunction

endpackage

// File: sv/encoder_button_event_classifier.sv
// channel   valid      stall      payload
// ------    --------   --------   ---------------------------------------
// in        in_valid   in_stall   button_level, encoder_count
// out       out_valid  out_stall  event_code
// config    apb write/read of five 8-bit registers at byte address 4*index
//
// one item per cycle while in_stall is low; the event is computed in the
// accept cycle from the state registers and lands in the output register,
// or in the skid register while the output is stalled, which keeps the input
// open; in_stall rises only when the skid register is full
// rst_n clears the state counters and valid flags, loads config defaults
module encoder_button_event_classifier
#(
    parameter int COUNT_BITS = ebec_pkg::DEF_COUNT_BITS
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [ebec_pkg::ADDR_BITS-1:0] paddr,
    input  logic [ebec_pkg::DATA_BITS-1:0] pwdata,
    output logic [ebec_pkg::DATA_BITS-1:0] prdata,
    output logic                           pready,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic                           button_level,
    input  logic [ebec_pkg::ENC_PORT_BITS-1:0] encoder_count,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic [ebec_pkg::CODE_BITS-1:0] event_code
);
    import ebec_pkg::*;

    // bits of the counter actually compared
    localparam int CW = (COUNT_BITS < ENC_PORT_BITS) ? COUNT_BITS : ENC_PORT_BITS;

    tick_t press_debounce_reg, release_gap_reg, long_press_reg;
    tick_t fast_window_reg, step_threshold_reg;

    tick_t                 pressed_ticks_reg, pressed_ticks_next;
    tick_t                 released_ticks_reg, released_ticks_next;
    logic [CLICK_BITS-1:0] pending_clicks_reg, pending_clicks_next;
    tick_t                 ticks_since_step_reg, ticks_since_step_next;
    logic [CW-1:0]         last_count_reg, last_count_next;

    logic  out_valid_reg, out_valid_next;
    code_t out_code_reg, out_code_next;
    logic  skid_valid_reg, skid_valid_next;
    code_t skid_code_reg, skid_code_next;

    logic          cfg_write;
    reg_index_t    cfg_index;
    logic          in_fire, out_fire;
    logic          pressed, press_arrived, release_arrived;
    tick_t         p_inc, r_inc, ts_inc, after_long;
    logic [CLICK_BITS-1:0] pc_click;
    logic [CW-1:0] count, diff;
    logic          count_up, step;
    code_t         ev, base;

    // config port
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign cfg_index = reg_index_t'(paddr[ADDR_BITS-1:2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            press_debounce_reg <= RST_PRESS_DEBOUNCE;
            release_gap_reg    <= RST_RELEASE_GAP;
            long_press_reg     <= RST_LONG_PRESS;
            fast_window_reg    <= RST_FAST_WINDOW;
            step_threshold_reg <= RST_STEP_THRESHOLD;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_PRESS_DEBOUNCE: press_debounce_reg <= pwdata[TICK_BITS-1:0];
                REG_RELEASE_GAP:    release_gap_reg    <= pwdata[TICK_BITS-1:0];
                REG_LONG_PRESS:     long_press_reg     <= pwdata[TICK_BITS-1:0];
                REG_FAST_WINDOW:    fast_window_reg    <= pwdata[TICK_BITS-1:0];
                REG_STEP_THRESHOLD: step_threshold_reg <= pwdata[TICK_BITS-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        prdata = '0;
        unique case (cfg_index)
            REG_PRESS_DEBOUNCE: prdata = DATA_BITS'(press_debounce_reg);
            REG_RELEASE_GAP:    prdata = DATA_BITS'(release_gap_reg);
            REG_LONG_PRESS:     prdata = DATA_BITS'(long_press_reg);
            REG_FAST_WINDOW:    prdata = DATA_BITS'(fast_window_reg);
            REG_STEP_THRESHOLD: prdata = DATA_BITS'(step_threshold_reg);
            default:            prdata = '0;
        endcase
    end

    // handshakes
    assign in_stall = skid_valid_reg;
    assign in_fire  = in_valid && !skid_valid_reg;
    assign out_fire = out_valid_reg && !out_stall;

    // per-tick classification
    assign pressed         = !button_level;
    assign p_inc           = sat_inc(pressed_ticks_reg);
    assign r_inc           = sat_inc(released_ticks_reg);
    assign ts_inc          = sat_inc(ticks_since_step_reg);
    assign after_long      = sat_inc(long_press_reg);
    assign press_arrived   = pressed && (pressed_ticks_reg != TICK_MAX);
    assign release_arrived = !pressed && (released_ticks_reg != TICK_MAX);

    assign count    = encoder_count[CW-1:0];
    assign count_up = count > last_count_reg;
    assign diff     = count_up ? count - last_count_reg : last_count_reg - count;
    assign step     = diff >= CW'(step_threshold_reg);
    assign base     = count_up ? EV_RIGHT : EV_LEFT;

    always_comb
    begin
        pressed_ticks_next  = pressed ? p_inc : '0;
        released_ticks_next = pressed ? '0 : r_inc;
        pc_click            = pending_clicks_reg;
        ev                  = EV_NONE;

        if (press_arrived && p_inc == press_debounce_reg && pc_click != CLICK_MAX)
        begin
            pc_click = pc_click + CLICK_BITS'(1);
        end
        pending_clicks_next = pc_click;

        if (release_arrived && r_inc == release_gap_reg && pc_click != '0)
        begin
            ev                  = (pc_click > CLICK_BITS'(1)) ? EV_DOUBLE : EV_SHORT;
            pending_clicks_next = '0;
        end
        if (press_arrived && p_inc == long_press_reg)
        begin
            pressed_ticks_next  = after_long;
            pending_clicks_next = '0;
            ev                  = EV_LONG;
        end

        ticks_since_step_next = ts_inc;
        last_count_next       = last_count_reg;
        if (step)
        begin
            // held button wins over fast turning
            if (pressed_ticks_next != '0)
                ev = base + EV_PRESSED_OFS;
            else if (ts_inc <= fast_window_reg)
                ev = base + EV_FAST_OFS;
            else
                ev = base;
            pressed_ticks_next    = after_long;
            pending_clicks_next   = '0;
            last_count_next       = count;
            ticks_since_step_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pressed_ticks_reg    <= '0;
            released_ticks_reg   <= '0;
            pending_clicks_reg   <= '0;
            ticks_since_step_reg <= '0;
            last_count_reg       <= '0;
        end
        else if (in_fire)
        begin
            pressed_ticks_reg    <= pressed_ticks_next;
            released_ticks_reg   <= released_ticks_next;
            pending_clicks_reg   <= pending_clicks_next;
            ticks_since_step_reg <= ticks_since_step_next;
            last_count_reg       <= last_count_next;
        end
    end

    // output register with skid
    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_code_next   = out_code_reg;
        skid_valid_next = skid_valid_reg;
        skid_code_next  = skid_code_reg;
        if (skid_valid_reg)
        begin
            if (out_fire)
            begin
                out_code_next   = skid_code_reg;
                skid_valid_next = 1'b0;
            end
        end
        else if (in_fire)
        begin
            if (!out_valid_reg || out_fire)
            begin
                out_valid_next = 1'b1;
                out_code_next  = ev;
            end
            else
            begin
                skid_valid_next = 1'b1;
                skid_code_next  = ev;
            end
        end
        else if (out_fire)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_code_reg  <= out_code_next;
        skid_code_reg <= skid_code_next;
    end

    assign out_valid  = out_valid_reg;
    assign event_code = out_code_reg;

    // checks
    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid item held without an output item");

    a_code_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_code_reg <= EV_LAST))
        else $error("event code out of range");

    a_step_restart: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && step) |=> (ticks_since_step_reg == '0 && pressed_ticks_reg != '0
                               && pending_clicks_reg == '0))
        else $error("rotation step did not restart the tick counters");

    a_long_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && ev == EV_LONG) |=> (pending_clicks_reg == '0))
        else $error("long press left pending clicks");

endmodule
